/* rtl/core/att_pkg.sv */
// Shared types, widths and constants for the accelerometer tilt-angle pipeline.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package att_pkg;

  // Sample and angle formats
  localparam int RAW_BITS        = 16;
  localparam int SAMPLE_BITS     = 12;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_BITS      = 16;
  localparam int ORIENT_BITS     = 2;

  // Configuration port
  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LANDSCAPE_BELOW = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PORTRAIT_ABOVE  = 2'd1;
  localparam logic [CFG_BITS-1:0] LANDSCAPE_BELOW_RST = 12'd300;
  localparam logic [CFG_BITS-1:0] PORTRAIT_ABOVE_RST  = 12'd850;

  // Orientation codes
  localparam logic [ORIENT_BITS-1:0] ORIENT_NONE      = 2'd0;
  localparam logic [ORIENT_BITS-1:0] ORIENT_LANDSCAPE = 2'd1;
  localparam logic [ORIENT_BITS-1:0] ORIENT_PORTRAIT  = 2'd2;

  // Magnitude path
  localparam int MAG_BITS  = SAMPLE_BITS;          // |sample| up to 2^(SAMPLE_BITS-1)
  localparam int SQ_BITS   = 2 * SAMPLE_BITS - 1;  // |sample|^2
  localparam int SUM_BITS  = SQ_BITS + 1;          // x^2 + y^2
  localparam int LOG_BITS  = $clog2(SUM_BITS);
  localparam int K_BITS    = 5;                    // normalizing shift, 19..30
  localparam int K_BASE    = 61;                   // k = (K_BASE - msb) / 2
  localparam int RAD_BITS  = 62;                   // normalized radicand
  localparam int RES_BITS  = 62;                   // square-root partial result
  localparam int ROOT_BITS = 31;                   // final root and scaled |z|
  localparam int SQRT_STEPS = 31;

  // CORDIC vectoring
  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 34;                // x/y datapath, signed
  localparam int TAB_FRAC     = 20;                // table units: 2^-20 degree
  localparam int ACC_W        = 29;                // angle accumulator, signed
  localparam int ANG_INT_W    = ACC_W + 1;
  localparam int ROUND_SH     = TAB_FRAC - ANGLE_FRAC_BITS;

  typedef struct packed {
    logic [RAW_BITS-1:0] raw_x;
    logic [RAW_BITS-1:0] raw_y;
    logic [RAW_BITS-1:0] raw_z;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [ANGLE_BITS-1:0]  tilt_angle;
    logic                          angle_valid;
    logic [ORIENT_BITS-1:0]        orientation;
  } out_t;

  // Per-reading data that rides along the whole pipeline
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic [ORIENT_BITS-1:0]        orientation;
    logic                          angle_ok;
    logic                          z_zero;
    logic                          z_neg;
  } side_t;

  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;
    logic [RES_BITS-1:0]  res;
    logic [ROOT_BITS-1:0] zx;
    side_t                side;
  } sqrt_bus_t;

  typedef struct packed {
    logic signed [CW-1:0]    xv;
    logic signed [CW-1:0]    yv;
    logic signed [ACC_W-1:0] acc;
    side_t                   side;
  } cordic_bus_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] landscape_below;
    logic [CFG_BITS-1:0] portrait_above;
  } cfg_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic [ACC_W-1:0] atan_tab(input int idx);
    logic [ACC_W-1:0] v;
    case (idx)
      0:  v = 29'd47185920;
      1:  v = 29'd27855475;
      2:  v = 29'd14718068;
      3:  v = 29'd7471121;
      4:  v = 29'd3750058;
      5:  v = 29'd1876857;
      6:  v = 29'd938658;
      7:  v = 29'd469357;
      8:  v = 29'd234682;
      9:  v = 29'd117342;
      10: v = 29'd58671;
      11: v = 29'd29335;
      12: v = 29'd14668;
      13: v = 29'd7334;
      14: v = 29'd3667;
      15: v = 29'd1833;
      16: v = 29'd917;
      17: v = 29'd458;
      18: v = 29'd229;
      19: v = 29'd115;
      20: v = 29'd57;
      21: v = 29'd29;
      22: v = 29'd14;
      23: v = 29'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/accel_tilt_angle.sv */
// Top level of the accelerometer tilt-angle pipeline: config registers,
// front end, root and CORDIC cell chains, rounding and output register. Uses att_pkg.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------
//   input    | in_valid / in_stall     | in_data  (raw_x, raw_y, raw_z)
//   result   | out_valid / out_stall   | out_data (samples, angle, class)
//   config   | cfg_we                  | cfg_index, cfg_wdata
//
// One reading enters per cycle when nothing stalls and passes 59 register stages:
// 3 front-end stages, 31 square-root cells, 24 CORDIC cells and the rounding stage.
// Every stage holds its own valid bit and moves on when the next one is free, so
// a held output stalls only stages that are full. Synchronous reset clears valid
// bits and loads the threshold defaults; there is no clearing pass.
`default_nettype none

module accel_tilt_angle
  import att_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire in_t                     in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output out_t                         out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

  localparam logic signed [ACC_W-1:0] MAX_ACC = ACC_W'(90) <<< TAB_FRAC;
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (ROUND_SH - 1);
  localparam logic signed [ANG_INT_W-1:0] RIGHT_ANGLE = ANG_INT_W'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ANG_INT_W-1:0] ANG_MAX = ANG_INT_W'((1 << (ANGLE_BITS - 1)) - 1);
  localparam logic signed [ANG_INT_W-1:0] ANG_MIN = -(ANG_MAX + ANG_INT_W'(1));

  // Configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.landscape_below <= LANDSCAPE_BELOW_RST;
      cfg_r.portrait_above  <= PORTRAIT_ABOVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LANDSCAPE_BELOW: cfg_r.landscape_below <= cfg_wdata;
        CFG_PORTRAIT_ABOVE:  cfg_r.portrait_above  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end
  logic      prep_ready;
  sqrt_bus_t sq_bus [SQRT_STEPS+1];
  logic      sq_vld [SQRT_STEPS+1];
  logic      sq_rdy [SQRT_STEPS+1];

  assign in_stall = !prep_ready;

  att_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .up_ready (prep_ready),
    .cfg      (cfg_r),
    .out_vld  (sq_vld[0]),
    .out_bus  (sq_bus[0]),
    .dn_ready (sq_rdy[0])
  );

  // Square-root chain
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    att_sqrt_cell #(.STEP(j)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[j]),
      .in_bus   (sq_bus[j]),
      .up_ready (sq_rdy[j]),
      .out_vld  (sq_vld[j+1]),
      .out_bus  (sq_bus[j+1]),
      .dn_ready (sq_rdy[j+1])
    );
  end

  // CORDIC chain, starting from (|z| scaled, root)
  cordic_bus_t cd_bus [CORDIC_STEPS+1];
  logic        cd_vld [CORDIC_STEPS+1];
  logic        cd_rdy [CORDIC_STEPS+1];

  assign cd_vld[0]            = sq_vld[SQRT_STEPS];
  assign sq_rdy[SQRT_STEPS]   = cd_rdy[0];
  assign cd_bus[0].xv         = CW'(sq_bus[SQRT_STEPS].zx);
  assign cd_bus[0].yv         = CW'(sq_bus[SQRT_STEPS].res[ROOT_BITS-1:0]);
  assign cd_bus[0].acc        = '0;
  assign cd_bus[0].side       = sq_bus[SQRT_STEPS].side;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    att_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (cd_vld[i]),
      .in_bus   (cd_bus[i]),
      .up_ready (cd_rdy[i]),
      .out_vld  (cd_vld[i+1]),
      .out_bus  (cd_bus[i+1]),
      .dn_ready (cd_rdy[i+1])
    );
  end

  // Clamp, round half up, apply sign and special cases
  cordic_bus_t              fin;
  logic signed [ACC_W-1:0]  acc_c;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ANG_INT_W-1:0] ang, ang_sel;
  out_t                     out_nxt;
  logic                     out_valid_r;
  out_t                     out_data_r;
  logic                     fin_ready;

  assign fin = cd_bus[CORDIC_STEPS];

  always_comb begin
    acc_c = fin.acc;
    if (fin.acc[ACC_W-1]) begin
      acc_c = '0;
    end else if (fin.acc > MAX_ACC) begin
      acc_c = MAX_ACC;
    end
    rnd = (acc_c + HALF) >>> ROUND_SH;
    ang = ANG_INT_W'(rnd);
    if (fin.side.z_neg) begin
      ang = -ang;
    end
    if (!fin.side.angle_ok) begin
      ang_sel = '0;
    end else if (fin.side.z_zero) begin
      ang_sel = RIGHT_ANGLE;
    end else begin
      ang_sel = ang;
    end
    if (ang_sel > ANG_MAX) begin
      ang_sel = ANG_MAX;
    end else if (ang_sel < ANG_MIN) begin
      ang_sel = ANG_MIN;
    end
    out_nxt.accel_x     = fin.side.accel_x;
    out_nxt.accel_y     = fin.side.accel_y;
    out_nxt.accel_z     = fin.side.accel_z;
    out_nxt.tilt_angle  = ang_sel[ANGLE_BITS-1:0];
    out_nxt.angle_valid = fin.side.angle_ok;
    out_nxt.orientation = fin.side.orientation;
  end

  assign fin_ready              = !out_valid_r || !out_stall;
  assign cd_rdy[CORDIC_STEPS]   = fin_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= cd_vld[CORDIC_STEPS];
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (fin_ready && cd_vld[CORDIC_STEPS]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/att_prep.sv */
// Front end: sample extraction, squares, normalization ahead of the root chain.
// Three handshaked stages; depends on att_pkg.
`default_nettype none

module att_prep
  import att_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_vld,
  input  wire in_t  in_item,
  output logic      up_ready,
  input  wire cfg_t cfg,
  output logic      out_vld,
  output sqrt_bus_t out_bus,
  input  wire logic dn_ready
);

  // Stage A: samples, magnitudes, squares, flags
  logic                  a_vld_r;
  side_t                 a_side_r;
  logic [SQ_BITS-1:0]    a_sqx_r, a_sqy_r, a_sqz_r;
  logic [MAG_BITS-1:0]   a_az_r;
  // Stage B: sum and max
  logic                  b_vld_r;
  side_t                 b_side_r;
  logic [SUM_BITS-1:0]   b_s_r, b_m_r;
  logic [MAG_BITS-1:0]   b_az_r;
  // Stage C is the output register
  logic                  c_vld_r;
  sqrt_bus_t             c_bus_r;

  logic a_ready, b_ready, c_ready;

  assign c_ready  = !c_vld_r || dn_ready;
  assign b_ready  = !b_vld_r || c_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign up_ready = a_ready;

  // Stage A combinational
  logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
  logic [MAG_BITS-1:0]           mx, my, mz;
  logic [2*MAG_BITS-1:0]         px, py, pz;
  side_t                         a_side_nxt;

  function automatic logic [MAG_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
    return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    sx = in_item.raw_x[RAW_BITS-1 -: SAMPLE_BITS];
    sy = in_item.raw_y[RAW_BITS-1 -: SAMPLE_BITS];
    sz = in_item.raw_z[RAW_BITS-1 -: SAMPLE_BITS];
    mx = mag(sx);
    my = mag(sy);
    mz = mag(sz);
    px = mx * mx;
    py = my * my;
    pz = mz * mz;
    a_side_nxt.accel_x  = sx;
    a_side_nxt.accel_y  = sy;
    a_side_nxt.accel_z  = sz;
    a_side_nxt.angle_ok = (mx != '0) || (my != '0) || (mz != '0);
    a_side_nxt.z_zero   = (mz == '0);
    a_side_nxt.z_neg    = sz[SAMPLE_BITS-1];
    // landscape test wins when both hold
    if (mx < cfg.landscape_below) begin
      a_side_nxt.orientation = ORIENT_LANDSCAPE;
    end else if (mx > cfg.portrait_above) begin
      a_side_nxt.orientation = ORIENT_PORTRAIT;
    end else begin
      a_side_nxt.orientation = ORIENT_NONE;
    end
  end

  // Stage B combinational
  logic [SUM_BITS-1:0] s_nxt, m_nxt;

  always_comb begin
    s_nxt = SUM_BITS'(a_sqx_r) + SUM_BITS'(a_sqy_r);
    m_nxt = (s_nxt > SUM_BITS'(a_sqz_r)) ? s_nxt : SUM_BITS'(a_sqz_r);
  end

  // Stage C combinational: shift so the larger term sits near the top of 62 bits
  logic [LOG_BITS-1:0] msb;
  logic [K_BITS:0]     kdiff;
  logic [K_BITS-1:0]   k;
  logic [RAD_BITS-1:0] zsh;
  sqrt_bus_t           c_bus_nxt;

  always_comb begin
    msb = '0;
    for (int i = 0; i < SUM_BITS; i++) begin
      if (b_m_r[i]) begin
        msb = LOG_BITS'(i);
      end
    end
    kdiff = (K_BITS+1)'(K_BASE) - (K_BITS+1)'(msb);
    k     = kdiff[K_BITS:1];
    zsh   = RAD_BITS'(b_az_r) << k;
    c_bus_nxt.rad  = RAD_BITS'(b_s_r) << {k, 1'b0};
    c_bus_nxt.res  = '0;
    c_bus_nxt.zx   = zsh[ROOT_BITS-1:0];
    c_bus_nxt.side = b_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_r <= in_vld;
      end
      if (b_ready) begin
        b_vld_r <= a_vld_r;
      end
      if (c_ready) begin
        c_vld_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_vld) begin
      a_side_r <= a_side_nxt;
      a_sqx_r  <= px[SQ_BITS-1:0];
      a_sqy_r  <= py[SQ_BITS-1:0];
      a_sqz_r  <= pz[SQ_BITS-1:0];
      a_az_r   <= mz;
    end
    if (b_ready && a_vld_r) begin
      b_side_r <= a_side_r;
      b_s_r    <= s_nxt;
      b_m_r    <= m_nxt;
      b_az_r   <= a_az_r;
    end
    if (c_ready && b_vld_r) begin
      c_bus_r <= c_bus_nxt;
    end
  end

  assign out_vld = c_vld_r;
  assign out_bus = c_bus_r;

endmodule

`default_nettype wire

/* rtl/core/att_sqrt_cell.sv */
// One digit-pair step of the restoring integer square root.
// Cell STEP of the root chain; depends on att_pkg.
`default_nettype none

module att_sqrt_cell
  import att_pkg::*;
#(
  parameter int STEP = 0
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_vld,
  input  wire sqrt_bus_t in_bus,
  output logic           up_ready,
  output logic           out_vld,
  output sqrt_bus_t      out_bus,
  input  wire logic      dn_ready
);

  localparam logic [RES_BITS-1:0] BIT = RES_BITS'(1) << (2 * (SQRT_STEPS - 1 - STEP));

  logic      vld_r;
  sqrt_bus_t bus_r;
  sqrt_bus_t bus_nxt;
  logic [RES_BITS:0] trial;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    bus_nxt = in_bus;
    trial   = {1'b0, in_bus.res} + {1'b0, BIT};
    if ({1'b0, in_bus.rad} >= trial) begin
      bus_nxt.rad = in_bus.rad - trial[RAD_BITS-1:0];
      bus_nxt.res = (in_bus.res >> 1) + BIT;
    end else begin
      bus_nxt.res = in_bus.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_vld) begin
      bus_r <= bus_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_bus = bus_r;

endmodule

`default_nettype wire

/* rtl/core/att_cordic_cell.sv */
// One CORDIC vectoring micro-rotation with its angle-table term.
// Cell STEP of the rotation chain; depends on att_pkg.
`default_nettype none

module att_cordic_cell
  import att_pkg::*;
#(
  parameter int STEP = 0
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire cordic_bus_t in_bus,
  output logic             up_ready,
  output logic             out_vld,
  output cordic_bus_t      out_bus,
  input  wire logic        dn_ready
);

  localparam logic signed [ACC_W-1:0] ANG = atan_tab(STEP);

  logic        vld_r;
  cordic_bus_t bus_r;
  cordic_bus_t bus_nxt;
  logic signed [CW-1:0] xs, ys;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    bus_nxt = in_bus;
    xs = in_bus.xv >>> STEP;
    ys = in_bus.yv >>> STEP;
    // rotate toward the x axis
    if (!in_bus.yv[CW-1]) begin
      bus_nxt.xv  = in_bus.xv + ys;
      bus_nxt.yv  = in_bus.yv - xs;
      bus_nxt.acc = in_bus.acc + ANG;
    end else begin
      bus_nxt.xv  = in_bus.xv - ys;
      bus_nxt.yv  = in_bus.yv + xs;
      bus_nxt.acc = in_bus.acc - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_vld) begin
      bus_r <= bus_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_bus = bus_r;

endmodule

`default_nettype wire
